/* rtl/adzs_pkg.sv */
// ----------------------------------------------------------------------------
// adzs_pkg
// Shared types and constants for the analog axis deadzone scaler.
// ----------------------------------------------------------------------------
package adzs_pkg;

    localparam int DEF_SAMPLE_BITS = 12;
    localparam int DIV_STAGES      = 8;

    localparam logic [7:0] AXIS_CENTER  = 8'h80;
    localparam logic [7:0] AXIS_LOW_TOP = 8'h7F;
    localparam logic [7:0] AXIS_HI_BASE = 8'h81;
    localparam logic [7:0] AXIS_FULL    = 8'hFF;
    localparam logic [7:0] AXIS_ONE     = 8'h01;
    localparam logic [7:0] AXIS_ZERO    = 8'h00;

    localparam logic [7:0] RST_RANGE_LOW  = 8'd0;
    localparam logic [7:0] RST_RANGE_HIGH = 8'd255;
    localparam logic [7:0] RST_REST_POINT = 8'd128;
    localparam logic [7:0] RST_DEAD_WIDTH = 8'd15;
    localparam logic [7:0] RST_EDGE_TRIM  = 8'd4;

    typedef enum logic [2:0] {
        REG_RANGE_LOW    = 3'd0,
        REG_RANGE_HIGH   = 3'd1,
        REG_REST_POINT   = 3'd2,
        REG_DEAD_WIDTH   = 3'd3,
        REG_EDGE_TRIM    = 3'd4,
        REG_REVERSE_AXIS = 3'd5,
        REG_TRIGGER_MODE = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] range_low;
        logic [7:0] range_high;
        logic [7:0] rest_point;
        logic [7:0] dead_width;
        logic [7:0] edge_trim;
        logic       reverse_axis;
        logic       trigger_mode;
    } cfg_t;

    // Payload after region selection: interpolation window and endpoints
    typedef struct packed {
        logic       direct;
        logic [7:0] value;
        logic [7:0] s;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] a;
        logic [7:0] b;
    } sel_t;

    // Payload travelling along the divider cells
    typedef struct packed {
        logic       direct;
        logic [7:0] value;
        logic       neg;
        logic [7:0] span;
        logic [7:0] rem;
        logic [7:0] work;
    } div_t;

endpackage

/* rtl/adzs_front.sv */
// ----------------------------------------------------------------------------
// adzs_front
// Sample reduction, region selection and the numerator multiply.
// ----------------------------------------------------------------------------
module adzs_front
    import adzs_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   up_valid,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                   up_ready,
    output logic                   down_valid,
    output div_t                   down_data,
    input  logic                   down_ready
);

    logic       sel_valid_reg;
    sel_t       sel_reg;
    sel_t       sel_next;
    logic       sel_ready;
    logic       mul_valid_reg;
    div_t       mul_reg;
    div_t       mul_next;
    logic       mul_ready;

    logic [7:0] s;
    logic [8:0] s9;
    logic [8:0] floor9;
    logic [8:0] c_plus_d;
    logic [8:0] s_plus_d;
    logic [7:0] mag;
    logic       neg;
    logic [15:0] prod;

    assign s        = sample[SAMPLE_BITS-1 -: 8];
    assign s9       = {1'b0, s};
    assign floor9   = {1'b0, cfg.range_low} + {1'b0, cfg.dead_width};
    assign c_plus_d = {1'b0, cfg.rest_point} + {1'b0, cfg.dead_width};
    assign s_plus_d = s9 + {1'b0, cfg.dead_width};

    always_comb
    begin
        sel_next        = '0;
        sel_next.s      = s;
        sel_next.direct = 1'b0;
        sel_next.value  = AXIS_ZERO;
        if (cfg.trigger_mode)
        begin
            sel_next.lo = floor9[7:0];
            sel_next.hi = cfg.range_high - cfg.edge_trim;
            sel_next.a  = cfg.reverse_axis ? AXIS_FULL : AXIS_ONE;
            sel_next.b  = cfg.reverse_axis ? AXIS_ONE : AXIS_FULL;
            if (s9 <= floor9)
            begin
                sel_next.direct = 1'b1;
                sel_next.value  = AXIS_ZERO;
            end
        end
        else if ((s_plus_d > {1'b0, cfg.rest_point}) && (s9 < c_plus_d))
        begin
            sel_next.direct = 1'b1;
            sel_next.value  = AXIS_CENTER;
        end
        else if (s < cfg.rest_point)
        begin
            sel_next.lo = cfg.range_low + cfg.edge_trim;
            sel_next.hi = cfg.rest_point - cfg.dead_width;
            sel_next.a  = cfg.reverse_axis ? AXIS_FULL : AXIS_ZERO;
            sel_next.b  = cfg.reverse_axis ? AXIS_HI_BASE : AXIS_LOW_TOP;
        end
        else if (s > cfg.rest_point)
        begin
            sel_next.lo = c_plus_d[7:0];
            sel_next.hi = cfg.range_high - cfg.edge_trim;
            sel_next.a  = cfg.reverse_axis ? AXIS_LOW_TOP : AXIS_HI_BASE;
            sel_next.b  = cfg.reverse_axis ? AXIS_ZERO : AXIS_FULL;
        end
        else
        begin
            sel_next.direct = 1'b1;
            sel_next.value  = AXIS_CENTER;
        end
    end

    // Clamp, zero span, then form |x - lo| * |b - a|
    assign neg  = sel_reg.b < sel_reg.a;
    assign mag  = neg ? (sel_reg.a - sel_reg.b) : (sel_reg.b - sel_reg.a);
    assign prod = 16'(sel_reg.s - sel_reg.lo) * 16'(mag);

    always_comb
    begin
        mul_next        = '0;
        mul_next.neg    = neg;
        mul_next.span   = sel_reg.hi - sel_reg.lo;
        mul_next.rem    = prod[15:8];
        mul_next.work   = prod[7:0];
        mul_next.value  = sel_reg.a;
        mul_next.direct = 1'b0;
        if (sel_reg.direct)
        begin
            mul_next.direct = 1'b1;
            mul_next.value  = sel_reg.value;
        end
        else if (sel_reg.s < sel_reg.lo)
        begin
            mul_next.direct = 1'b1;
            mul_next.value  = sel_reg.a;
        end
        else if (sel_reg.s > sel_reg.hi)
        begin
            mul_next.direct = 1'b1;
            mul_next.value  = sel_reg.b;
        end
        else if (sel_reg.hi == sel_reg.lo)
        begin
            mul_next.direct = 1'b1;
            mul_next.value  = sel_reg.a;
        end
    end

    assign mul_ready = !mul_valid_reg || down_ready;
    assign sel_ready = !sel_valid_reg || mul_ready;
    assign up_ready  = sel_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
        end
        else
        begin
            if (sel_ready)
            begin
                sel_valid_reg <= up_valid;
            end
            if (mul_ready)
            begin
                mul_valid_reg <= sel_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel_ready && up_valid)
        begin
            sel_reg <= sel_next;
        end
        if (mul_ready && sel_valid_reg)
        begin
            mul_reg <= mul_next;
        end
    end

    assign down_valid = mul_valid_reg;
    assign down_data  = mul_reg;

endmodule

/* rtl/adzs_div_cell.sv */
// ----------------------------------------------------------------------------
// adzs_div_cell
// One restoring-division cell: develops one quotient bit per beat.
// ----------------------------------------------------------------------------
module adzs_div_cell
    import adzs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    input  div_t up_data,
    output logic up_ready,
    output logic down_valid,
    output div_t down_data,
    input  logic down_ready
);

    logic       valid_reg;
    div_t       data_reg;
    div_t       data_next;
    logic [8:0] trial;
    logic       qbit;

    // Shift in the next dividend bit, subtract the span where it fits
    assign trial = {up_data.rem, up_data.work[7]};
    assign qbit  = trial >= {1'b0, up_data.span};

    always_comb
    begin
        data_next      = up_data;
        data_next.rem  = qbit ? 8'(trial - {1'b0, up_data.span}) : trial[7:0];
        data_next.work = {up_data.work[6:0], qbit};
    end

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !data_reg.direct |-> data_reg.rem < data_reg.span)
        else $error("partial remainder not below span");

endmodule

/* rtl/analog_axis_deadzone_scaler.sv */
// ----------------------------------------------------------------------------
// analog_axis_deadzone_scaler
// Converter sample to axis byte with deadzone and clamped linear scaling.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// in       sink       in_valid/in_stall  raw_sample[SAMPLE_BITS-1:0]
// out      source     out_valid/out_stall axis_value[7:0]
// cfg      sink       cfg_valid/cfg_ready cfg_index[2:0], cfg_data[7:0]
//
// One sample accepted per cycle while in_stall is low; on its way to out_valid each
// passes two front stages, one cell per quotient bit (8) and the output register.
// Throughput is one beat a cycle while out_stall does not hold the pipeline.
// Reset clears all valids and loads the register reset values.
// out_stall holds the output beat; bubbles upstream still fill before
// in_stall rises. cfg_ready is always high.
// ----------------------------------------------------------------------------
module analog_axis_deadzone_scaler
    import adzs_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] raw_sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             axis_value,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [7:0]             cfg_data
);

    cfg_t       cfg_reg;
    logic       front_ready;
    logic       cell_valid [DIV_STAGES+1];
    div_t       cell_data  [DIV_STAGES+1];
    logic       cell_ready [DIV_STAGES+1];
    logic       out_valid_reg;
    logic [7:0] out_value_reg;
    logic [7:0] out_value_next;
    logic       out_ready;
    div_t       last;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_low    <= RST_RANGE_LOW;
            cfg_reg.range_high   <= RST_RANGE_HIGH;
            cfg_reg.rest_point   <= RST_REST_POINT;
            cfg_reg.dead_width   <= RST_DEAD_WIDTH;
            cfg_reg.edge_trim    <= RST_EDGE_TRIM;
            cfg_reg.reverse_axis <= 1'b0;
            cfg_reg.trigger_mode <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_RANGE_LOW:    cfg_reg.range_low    <= cfg_data;
                REG_RANGE_HIGH:   cfg_reg.range_high   <= cfg_data;
                REG_REST_POINT:   cfg_reg.rest_point   <= cfg_data;
                REG_DEAD_WIDTH:   cfg_reg.dead_width   <= cfg_data;
                REG_EDGE_TRIM:    cfg_reg.edge_trim    <= cfg_data;
                REG_REVERSE_AXIS: cfg_reg.reverse_axis <= cfg_data[0];
                REG_TRIGGER_MODE: cfg_reg.trigger_mode <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    adzs_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .up_valid   (in_valid),
        .sample     (raw_sample),
        .up_ready   (front_ready),
        .down_valid (cell_valid[0]),
        .down_data  (cell_data[0]),
        .down_ready (cell_ready[0])
    );

    assign in_stall = !front_ready;

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_cell
        adzs_div_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (cell_valid[i]),
            .up_data    (cell_data[i]),
            .up_ready   (cell_ready[i]),
            .down_valid (cell_valid[i+1]),
            .down_data  (cell_data[i+1]),
            .down_ready (cell_ready[i+1])
        );
    end

    // Apply the sign of (b - a) to the quotient and add the start point
    assign last           = cell_data[DIV_STAGES];
    assign out_value_next = last.direct ? last.value :
                            (last.neg ? (last.value - last.work)
                                      : (last.value + last.work));

    assign out_ready              = !out_valid_reg || !out_stall;
    assign cell_ready[DIV_STAGES] = out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= cell_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && cell_valid[DIV_STAGES])
        begin
            out_value_reg <= out_value_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign axis_value = out_value_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while output side free");

    a_out_from_last_cell: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cell_valid[DIV_STAGES]))
        else $error("output beat without a finished cell beat");

endmodule
